// File: rtl/pfid_pkg.sv
// ----------------------------------------------------------------------------
// pfid_pkg
// Shared constants, types and the bucket hash for the fan index dedup block.
// ----------------------------------------------------------------------------
package pfid_pkg;

	localparam int IDX_W         = 20;
	localparam int KEY_W         = 3 * IDX_W;
	localparam int TABLE_ENTRIES = 1024;
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = ADDR_W + 1;
	localparam int SLOT_W        = 10;
	localparam int IN_DATA_W     = 64;
	localparam int OUT_DATA_W    = 16;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic          valid;
		key_t          key;
		addr_t         slot;
	} entry_t;

	typedef struct packed {
		addr_t slot;
		logic  is_new;
		logic  overflow;
	} lk_res_t;

	function automatic addr_t bucket_of(input key_t key);
		logic [IDX_W-1:0] h;
		h = key[3*IDX_W-1:2*IDX_W] ^ key[2*IDX_W-1:IDX_W] ^ key[IDX_W-1:0];
		return h[ADDR_W-1:0];
	endfunction

endpackage

// File: rtl/pfid_lookup.sv
// ----------------------------------------------------------------------------
// pfid_lookup
// Hashed key table with linear probing, slot allocation and clear sweep.
// ----------------------------------------------------------------------------
module pfid_lookup (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             start,
	input  pfid_pkg::key_t   key,
	output logic             idle,
	output logic             res_valid,
	input  logic             res_take,
	output pfid_pkg::lk_res_t res
);
	import pfid_pkg::*;

	typedef enum logic [3:0] {
		L_CLR  = 4'b0001,
		L_IDLE = 4'b0010,
		L_RD   = 4'b0100,
		L_CMP  = 4'b1000
	} lstate_t;

	lstate_t          state_q;
	addr_t            addr_q;
	logic [CNT_W-1:0] probe_q;
	logic [CNT_W-1:0] ucount_q;
	key_t             key_q;
	entry_t           rd_q;
	entry_t           mem [TABLE_ENTRIES];

	logic   hit, miss, wrapped, done, full, insert, we;
	entry_t wdata;

	assign hit     = rd_q.valid && (rd_q.key == key_q);
	assign miss    = !rd_q.valid;
	assign wrapped = rd_q.valid && !hit && (probe_q == CNT_W'(TABLE_ENTRIES - 1));
	assign done    = hit || miss || wrapped;
	assign full    = ucount_q >= CNT_W'(TABLE_ENTRIES);
	assign insert  = (state_q == L_CMP) && miss && !full && res_take;

	assign idle      = (state_q == L_IDLE);
	assign res_valid = (state_q == L_CMP) && done;

	always_comb begin
		res = '0;
		if (hit) begin
			res.slot = rd_q.slot;
		end else if (miss && !full) begin
			res.slot   = ucount_q[ADDR_W-1:0];
			res.is_new = 1'b1;
		end else begin
			res.overflow = 1'b1;
		end
	end

	always_comb begin
		we    = 1'b0;
		wdata = '0;
		if (state_q == L_CLR) begin
			we = 1'b1;
		end else if (insert) begin
			we          = 1'b1;
			wdata.valid = 1'b1;
			wdata.key   = key_q;
			wdata.slot  = ucount_q[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_q] <= wdata;
		end
		if (state_q == L_RD) begin
			rd_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= L_CLR;
			addr_q   <= '0;
			probe_q  <= '0;
			ucount_q <= '0;
		end else begin
			case (state_q)
				L_CLR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_W'(TABLE_ENTRIES - 1)) begin
						state_q <= L_IDLE;
					end
				end
				L_IDLE: begin
					if (clr) begin
						state_q  <= L_CLR;
						addr_q   <= '0;
						ucount_q <= '0;
					end else if (start) begin
						state_q <= L_RD;
						addr_q  <= bucket_of(key);
						probe_q <= '0;
					end
				end
				L_RD: begin
					state_q <= L_CMP;
				end
				L_CMP: begin
					if (done) begin
						if (res_take) begin
							state_q <= L_IDLE;
							if (insert) begin
								ucount_q <= ucount_q + 1'b1;
							end
						end
					end else begin
						// occupied by another key: next bucket, wraps at table end
						addr_q  <= addr_q + 1'b1;
						probe_q <= probe_q + 1'b1;
						state_q <= L_RD;
					end
				end
				default: state_q <= L_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && start) begin
			key_q <= key;
		end
	end

endmodule

// File: rtl/polygon_fan_index_dedup.sv
// ----------------------------------------------------------------------------
// polygon_fan_index_dedup
// Fan triangulation of polygon corners with vertex index deduplication.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat per corner or per clear command. tuser[0] is
// the command (1 = start new mesh), tuser[1] flags the first corner of a
// polygon, tdata carries the vertex, normal and texcoord indices.
// Output channel m_*: three beats per triangle (first, previous, current),
// tlast on the third. tdata holds the vertex slot, tuser the new-vertex and
// overflow flags.
// The first two corners of a polygon only latch their keys.
// From the third corner on, each corner runs three table lookups in turn;
// a lookup issues its key, then reads and compares one entry of the
// single-port table per probe, until a hit, an empty bucket or a full wrap.
// Results are registered into the output beat once the receiver can take
// them. A stalled receiver holds the output beat and the lookup engine
// waits on it.
// Reset, and every clear command, starts a sweep that marks all buckets
// empty; no beat is accepted during the sweep.
// ----------------------------------------------------------------------------
module polygon_fan_index_dedup (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// vertex_index, normal_index, texcoord_index, zero pad
	input  logic [pfid_pkg::IN_DATA_W-1:0]   s_tdata,
	// command, first_corner
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// vertex_slot, zero pad
	output logic [pfid_pkg::OUT_DATA_W-1:0]  m_tdata,
	// is_new, overflow
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast
);
	import pfid_pkg::*;

	typedef enum logic [1:0] {
		T_IDLE = 2'b01,
		T_RUN  = 2'b10
	} tstate_t;

	tstate_t    state_q;
	logic [1:0] corner_q;
	logic [1:0] idx_q;
	logic       issued_q;
	key_t       first_key_q, second_key_q, cur_key_q;

	logic       out_valid_q, out_new_q, out_ovf_q, out_last_q;
	addr_t      out_slot_q;

	logic       acc, clr, lk_start, lk_idle, lk_valid, take;
	key_t       in_key, lk_key;
	lk_res_t    lk_res;

	assign in_key   = {s_tdata[IDX_W-1:0], s_tdata[2*IDX_W-1:IDX_W],
		s_tdata[3*IDX_W-1:2*IDX_W]};
	assign s_tready = (state_q == T_IDLE) && lk_idle;
	assign acc      = s_tvalid && s_tready;
	assign clr      = acc && s_tuser[0];
	assign lk_start = (state_q == T_RUN) && !issued_q;
	assign take     = lk_valid && (!out_valid_q || m_tready);

	always_comb begin
		case (idx_q)
			2'd0:    lk_key = first_key_q;
			2'd1:    lk_key = second_key_q;
			default: lk_key = cur_key_q;
		endcase
	end

	pfid_lookup u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (clr),
		.start     (lk_start),
		.key       (lk_key),
		.idle      (lk_idle),
		.res_valid (lk_valid),
		.res_take  (take),
		.res       (lk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			corner_q    <= '0;
			idx_q       <= '0;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (acc) begin
						if (s_tuser[0]) begin
							corner_q <= '0;
						end else if (s_tuser[1] || corner_q == 2'd0) begin
							corner_q <= 2'd1;
						end else if (corner_q == 2'd1) begin
							corner_q <= 2'd2;
						end else begin
							idx_q    <= '0;
							issued_q <= 1'b0;
							state_q  <= T_RUN;
						end
					end
				end
				T_RUN: begin
					if (lk_start) begin
						issued_q <= 1'b1;
					end
					if (take) begin
						issued_q <= 1'b0;
						idx_q    <= idx_q + 1'b1;
						if (idx_q == 2'd2) begin
							state_q <= T_IDLE;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !s_tuser[0]) begin
			if (s_tuser[1] || corner_q == 2'd0) begin
				first_key_q <= in_key;
			end else if (corner_q == 2'd1) begin
				second_key_q <= in_key;
			end else begin
				cur_key_q <= in_key;
			end
		end
		// current corner becomes the previous one once its triangle is out
		if (state_q == T_RUN && take && idx_q == 2'd2) begin
			second_key_q <= cur_key_q;
		end
		if (take) begin
			out_slot_q <= lk_res.slot;
			out_new_q  <= lk_res.is_new;
			out_ovf_q  <= lk_res.overflow;
			out_last_q <= (idx_q == 2'd2);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - SLOT_W){1'b0}}, out_slot_q[SLOT_W-1:0]};
	assign m_tuser  = {out_ovf_q, out_new_q};
	assign m_tlast  = out_last_q;

endmodule

// File: rtl/pfid_checker.sv
// ----------------------------------------------------------------------------
// pfid_checker
// Port-level checks for the fan index dedup block, bound to the top level.
// ----------------------------------------------------------------------------
module pfid_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pfid_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]                      m_tuser,
	input logic                            m_tlast
);
	import pfid_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output beat changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("new vertex and overflow both set");

	a_ovf_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0)
		else $error("overflow beat with nonzero slot");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:SLOT_W] == '0)
		else $error("slot padding not zero");

endmodule

bind polygon_fan_index_dedup pfid_checker u_pfid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// File: sim/tb_polygon_fan_index_dedup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_fan_index_dedup
// Self-checking bench for the fan triangulation / vertex dedup block. A
// scoreboard mirrors the hashed key table and predicts every triangle corner
// beat. Stimulus covers short polygons, orphan corners, clears, hash
// collisions, and random meshes with key reuse, under random stalls.
// ----------------------------------------------------------------------------
module tb_polygon_fan_index_dedup;
	import pfid_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int NUM_ITEMS      = 300;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic              is_new;
		logic              overflow;
		logic              last;
	} corner_beat_t;

	class dedup_scoreboard;
		logic [KEY_W-1:0] keys [TABLE_ENTRIES];
		int               slots [TABLE_ENTRIES];
		bit               used [TABLE_ENTRIES];
		int               unique_cnt;
		int               corners;
		logic [KEY_W-1:0] fan_key;
		logic [KEY_W-1:0] prev_key;
		corner_beat_t     pending_beats [$];
		int               errors;
		int               triangles;
		int               overflow_beats;

		function void wipe();
			foreach (used[i]) used[i] = 0;
			unique_cnt = 0;
			corners = 0;
		endfunction

		function void resolve(logic [KEY_W-1:0] key, logic last);
			int b;
			int n;
			corner_beat_t r;
			b = int'(bucket_of(key));
			r.last = last;
			for (n = 0; n < TABLE_ENTRIES; n++) begin
				if (!used[b])
					break;
				if (keys[b] == key) begin
					r.slot = slots[b][SLOT_W-1:0];
					r.is_new = 1'b0;
					r.overflow = 1'b0;
					pending_beats.insert(pending_beats.size(), r);
					return;
				end
				b = (b + 1) % TABLE_ENTRIES;
			end
			if (n == TABLE_ENTRIES || unique_cnt >= TABLE_ENTRIES) begin
				r.slot = '0;
				r.is_new = 1'b0;
				r.overflow = 1'b1;
				overflow_beats++;
			end else begin
				used[b] = 1;
				keys[b] = key;
				slots[b] = unique_cnt;
				r.slot = unique_cnt[SLOT_W-1:0];
				r.is_new = 1'b1;
				r.overflow = 1'b0;
				unique_cnt++;
			end
			pending_beats.insert(pending_beats.size(), r);
		endfunction

		function void note_input(logic clr, logic fc, logic [IDX_W-1:0] v,
				logic [IDX_W-1:0] nrm, logic [IDX_W-1:0] tc);
			logic [KEY_W-1:0] key;
			if (clr) begin
				wipe();
				return;
			end
			key = {v, nrm, tc};
			if (fc || corners == 0) begin
				fan_key = key;
				corners = 1;
			end else if (corners == 1) begin
				prev_key = key;
				corners = 2;
			end else begin
				resolve(fan_key, 0);
				resolve(prev_key, 0);
				resolve(key, 1);
				prev_key = key;
				triangles++;
			end
		endfunction

		function void check_beat(logic [OUT_DATA_W-1:0] data, logic [1:0] user,
				logic tl);
			corner_beat_t e;
			if (pending_beats.size() == 0) begin
				$error("unexpected output beat slot=%0d", data[SLOT_W-1:0]);
				errors++;
				return;
			end
			e = pending_beats.pop_front();
			if (data !== {{(OUT_DATA_W-SLOT_W){1'b0}}, e.slot}) begin
				$error("vertex_slot: expected %0d, got %0d", e.slot, data);
				errors++;
			end
			if (user[0] !== e.is_new) begin
				$error("is_new: expected %0b, got %0b", e.is_new, user[0]);
				errors++;
			end
			if (user[1] !== e.overflow) begin
				$error("overflow: expected %0b, got %0b", e.overflow, user[1]);
				errors++;
			end
			if (tl !== e.last) begin
				$error("last: expected %0b, got %0b", e.last, tl);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  s_tvalid = 0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	dedup_scoreboard sb;
	bit              quiet = 0;
	int              stall_left = 0;
	int              idle_cycles = 0;
	int              items = 0;
	logic [KEY_W-1:0] pool [24];

	polygon_fan_index_dedup dut (.*);

	always #1 clk = ~clk;

	// output sink with random backpressure
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tuser, m_tlast);
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 0;
		end else if (!quiet && $urandom_range(7) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			m_tready <= 0;
		end else begin
			m_tready <= arst_n;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_beat(logic clr, logic fc, logic [IDX_W-1:0] v,
			logic [IDX_W-1:0] nrm, logic [IDX_W-1:0] tc);
		if (!quiet && $urandom_range(3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {{(IN_DATA_W-KEY_W){1'b0}}, tc, nrm, v};
		s_tuser  <= {fc, clr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(clr, fc, v, nrm, tc);
		items++;
	endtask

	task automatic send_corner(logic fc, logic [KEY_W-1:0] key);
		send_beat(0, fc, key[3*IDX_W-1:2*IDX_W], key[2*IDX_W-1:IDX_W], key[IDX_W-1:0]);
	endtask

	task automatic send_clear();
		send_beat(1, 1'($urandom_range(1)), IDX_W'($urandom), IDX_W'($urandom),
			IDX_W'($urandom));
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(9) < 6)
			return pool[$urandom_range(23)];
		return KEY_W'({$urandom, $urandom, $urandom});
	endfunction

	task automatic random_polygon();
		int n;
		n = ($urandom_range(5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
		// occasionally open a polygon without the start flag
		send_corner($urandom_range(19) != 0, pick_key());
		for (int i = 1; i < n; i++)
			send_corner(($urandom_range(30) == 0), pick_key());
	endtask

	initial begin
		sb = new();
		sb.wipe();
		foreach (pool[i]) pool[i] = KEY_W'({$urandom, $urandom, $urandom});
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// directed: short polygons, orphan corner, extremes, index zero, reuse
		send_clear();
		send_corner(0, {20'd5, 20'd0, 20'd0});
		send_corner(1, {20'd1, 20'd0, 20'd0});
		send_corner(0, {20'd2, 20'd0, 20'd0});
		send_corner(1, {20'hFFFFF, 20'hFFFFF, 20'hFFFFF});
		send_corner(0, {20'd1, 20'd0, 20'd0});
		send_corner(0, {20'd0, 20'd0, 20'd0});
		send_corner(0, {20'hFFFFF, 20'hFFFFF, 20'hFFFFF});
		send_corner(0, {20'd1, 20'd0, 20'd0});
		send_corner(1, {20'd0, 20'h12345, 20'hABCDE});
		send_corner(0, {20'h00001, 20'hFFFFF, 20'd0});
		send_corner(0, {20'hFFFFF, 20'd0, 20'hFFFFF});
		// colliding hashes force probing
		send_corner(0, {20'h00401, 20'd0, 20'd0});
		send_corner(0, {20'h00801, 20'd0, 20'd0});
		send_clear();
		send_corner(1, {20'd7, 20'd7, 20'd7});
		send_corner(0, {20'd8, 20'd8, 20'd8});

		while (items < NUM_ITEMS) begin
			if (items > NUM_ITEMS - 50)
				quiet = 1;
			if ($urandom_range(14) == 0)
				send_clear();
			random_polygon();
		end
		s_tvalid <= 0;

		while (sb.pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d input beats, %0d triangles, %0d overflow corners",
			items, sb.triangles, sb.overflow_beats);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// File: polygon_fan_index_dedup.f
rtl/pfid_pkg.sv
rtl/pfid_lookup.sv
rtl/polygon_fan_index_dedup.sv
rtl/pfid_checker.sv
sim/tb_polygon_fan_index_dedup.sv
